### design/deq_pkg.sv
// deq_pkg: shared types and constants for the double-ended queue
// holds the item structs, command and status codes, and ring sizing
// no dependencies
`default_nettype none

package deq_pkg;

    // ring sizing
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } t_out_item;

endpackage

`default_nettype wire

### design/double_ended_queue.sv
// double_ended_queue: deque of signed words kept in a ring memory
// depends on deq_pkg and deq_ram
//
//   port group   direction   handshake               payload
//   request      in          i_in_valid/o_in_stall   i_in_item (command, value)
//   result       out         o_out_valid/i_out_stall o_out_item (read_word, status, count)
//
// an item is handled in an accept cycle, which updates pointers and count and
// issues the memory write or read, and a finish cycle, which takes the registered read data
// into the output register, after which the next item is accepted
// the output register frees the request side as soon as the result is loaded
// a stalled result holds back the finish cycle until the output register drains
// reset clears pointers, count and valid flags; the memory is not cleared
`default_nettype none

module double_ended_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire deq_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output deq_pkg::t_out_item      o_out_item
);

    localparam logic [deq_pkg::IDX_W-1:0] LAST_IDX = deq_pkg::IDX_W'(deq_pkg::CAPACITY - 1);
    localparam logic [deq_pkg::CNT_W-1:0] FULL_CNT = deq_pkg::CNT_W'(deq_pkg::CAPACITY);

    logic [deq_pkg::IDX_W-1:0] r_head, n_head;
    logic [deq_pkg::IDX_W-1:0] r_tail, n_tail;
    logic [deq_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_busy;
    logic                      r_out_valid;
    deq_pkg::t_out_item        r_out_item;

    // item held between accept and result
    logic                      r_pend_read, n_pend_read;
    deq_pkg::t_status          r_pend_status, n_pend_status;

    logic                      accept;
    logic                      finish;
    logic                      wr_en;
    logic [deq_pkg::IDX_W-1:0] wr_addr;
    logic [deq_pkg::IDX_W-1:0] rd_addr;
    logic [deq_pkg::IDX_W-1:0] head_next, head_prev, tail_next, tail_prev;
    logic [deq_pkg::WORD_W-1:0] rd_data;
    logic                      is_empty, is_full;

    assign accept = i_in_valid && !r_busy;
    assign finish = r_busy && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ring neighbors of the end pointers
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == FULL_CNT);

    // command decode: pointer and count update, memory access
    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_pend_read   = 1'b0;
        n_pend_status = deq_pkg::ST_OK;
        wr_en         = 1'b0;
        wr_addr       = r_tail;
        rd_addr       = r_head;
        unique case (deq_pkg::t_cmd'(i_in_item.command))
            deq_pkg::CMD_PUSH_FRONT: begin
                if (is_full) begin
                    n_pend_status = deq_pkg::ST_FULL;
                end else begin
                    n_head  = head_prev;
                    wr_en   = 1'b1;
                    wr_addr = head_prev;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_pend_status = deq_pkg::ST_FULL;
                end else begin
                    n_tail  = tail_next;
                    wr_en   = 1'b1;
                    wr_addr = r_tail;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
                if (is_empty) begin
                    n_pend_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_pend_read = 1'b1;
                    rd_addr     = r_head;
                    if (deq_pkg::t_cmd'(i_in_item.command) == deq_pkg::CMD_POP_FRONT) begin
                        n_head  = head_next;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK: begin
                if (is_empty) begin
                    n_pend_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_pend_read = 1'b1;
                    rd_addr     = tail_prev;
                    if (deq_pkg::t_cmd'(i_in_item.command) == deq_pkg::CMD_POP_BACK) begin
                        n_tail  = tail_prev;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            deq_pkg::CMD_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // ring memory
    deq_ram #(
        .WIDTH(deq_pkg::WORD_W),
        .DEPTH(deq_pkg::CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (accept && wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_in_item.value),
        .i_rd_en  (accept && n_pend_read),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_busy  <= 1'b1;
            end else if (finish) begin
                r_busy  <= 1'b0;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pending item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_read   <= n_pend_read;
            r_pend_status <= n_pend_status;
        end
        if (finish) begin
            r_out_item.read_word <= r_pend_read ? rd_data : '0;
            r_out_item.status    <= r_pend_status;
            r_out_item.count     <= deq_pkg::COUNT_W'(r_count);
        end
    end

endmodule

`default_nettype wire

### design/deq_ram.sv
// deq_ram: generic single-write, single-read memory with registered read
// read data holds its value while no read is issued
// no dependencies
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/deq_checker.sv
// deq_checker: port-level checks for the double-ended queue
// depends on deq_pkg; bound to double_ended_queue
`default_nettype none

module deq_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire deq_pkg::t_in_item  i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire deq_pkg::t_out_item o_out_item
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // one item in flight: accepting blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while one is in flight");

    // empty error carries no word and a zero count
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == deq_pkg::ST_EMPTY
        |-> o_out_item.read_word == '0 && o_out_item.count == '0)
        else $error("empty error with word or count");

    // full error reports a full ring
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == deq_pkg::ST_FULL
        |-> o_out_item.read_word == '0
            && o_out_item.count == deq_pkg::COUNT_W'(deq_pkg::CAPACITY))
        else $error("full error with wrong count");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire

### verif/deq_result_checker.sv
// deq_result_checker: predicts and checks results of the double-ended queue
// watches the request and result channels, keeps its own ring, head, tail and count
// depends on deq_pkg
`default_nettype none

module deq_result_checker
    import deq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_mismatches,
    output int             o_outstanding,
    output int             o_checked,
    output int             o_empty_hits,
    output int             o_full_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted deque contents and pointers
    logic [WORD_W-1:0] ring_words [CAPACITY];
    logic [IDX_W-1:0]  front_idx;
    logic [IDX_W-1:0]  back_idx;
    logic [CNT_W-1:0]  held;

    // results owed by the block, oldest first
    t_out_item pending_results [$];

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("%0t: %s: expected word %0d status %0d count %0d,", $time, what,
                     want.read_word, want.status, want.count);
            $display("    got word %0d status %0d count %0d",
                     got.read_word, got.status, got.count);
        end
    endtask

    // apply one request to the predicted deque and queue its result
    task automatic predict_request(input t_in_item req);
        t_out_item        res;
        logic [IDX_W-1:0] last_idx;
        res = '0;
        res.status = ST_OK;
        last_idx = (back_idx == 0) ? IDX_W'(CAPACITY - 1) : back_idx - 1'b1;
        case (req.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (held >= CAPACITY) begin
                    res.status = ST_FULL;
                    o_full_hits++;
                end else if (req.command == CMD_PUSH_FRONT) begin
                    front_idx = (front_idx == 0) ? IDX_W'(CAPACITY - 1) : front_idx - 1'b1;
                    ring_words[front_idx] = req.value;
                    held++;
                end else begin
                    ring_words[back_idx] = req.value;
                    back_idx = (back_idx == IDX_W'(CAPACITY - 1)) ? '0 : back_idx + 1'b1;
                    held++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                    o_empty_hits++;
                end else begin
                    if (req.command == CMD_POP_FRONT || req.command == CMD_PEEK_FRONT) begin
                        res.read_word = ring_words[front_idx];
                    end else begin
                        res.read_word = ring_words[last_idx];
                    end
                    if (req.command == CMD_POP_FRONT) begin
                        front_idx = (front_idx == IDX_W'(CAPACITY - 1)) ? '0 : front_idx + 1'b1;
                        held--;
                    end else if (req.command == CMD_POP_BACK) begin
                        back_idx = last_idx;
                        held--;
                    end
                end
            end
            CMD_CLEAR: begin
                front_idx = '0;
                back_idx  = '0;
                held      = '0;
            end
            // the unused code leaves everything alone
            default: ;
        endcase
        res.count = COUNT_W'(held);
        pending_results.insert(pending_results.size(), res);
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            front_idx = '0;
            back_idx  = '0;
            held      = '0;
            pending_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
            o_empty_hits = 0;
            o_full_hits  = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_request(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, i_out_item);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    o_checked++;
                    if (i_out_item.read_word !== want.read_word ||
                        i_out_item.status !== want.status ||
                        i_out_item.count !== want.count) begin
                        report_mismatch("wrong result", want, i_out_item);
                    end
                end
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

`default_nettype wire

### verif/tb_double_ended_queue.sv
// tb_double_ended_queue: stimulus and verdict for the double-ended queue
// drives directed and random requests with random gaps and result stalls
// depends on deq_pkg, double_ended_queue and deq_result_checker
`default_nettype none

module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // the one command code the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_NOISE} t_mix;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    t_in_item  req_item;
    logic      res_valid;
    logic      res_stall;
    t_out_item res_item;

    int mismatches;
    int outstanding;
    int checked;
    int empty_hits;
    int full_hits;

    int          requests_sent;
    int unsigned cycle_count;
    bit          sender_quiet;
    bit          sink_quiet;

    double_ended_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_item   (req_item),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_item  (res_item)
    );

    deq_result_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .i_in_stall    (req_stall),
        .i_in_item     (req_item),
        .i_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .i_out_item    (res_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_empty_hits  (empty_hits),
        .o_full_hits   (full_hits)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // word to push, leaning on the extremes now and then
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // command mix for one random segment
    function automatic logic [CMD_W-1:0] pick_command(t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (roll < 70) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                if (roll < 90) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                return $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
            end
            MIX_SHRINK: begin
                if (roll < 25) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                if (roll < 80) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                return $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
            end
            default: return CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_RESERVED));
        endcase
    endfunction

    // offer one item after a random gap and hold it until accepted
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
        int       gap;
        t_in_item item;
        gap = sender_quiet ? 0 : $urandom_range(0, 16);
        item.command = cmd;
        item.value   = word;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    // result side: stall for a random stretch, then take one item
    initial begin
        int hold;
        res_stall <= 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            hold = sink_quiet ? 0 : $urandom_range(0, 16);
            if (hold > 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // stimulus and verdict
    initial begin
        t_mix mix;
        int   seg_len;
        bit   filled;
        requests_sent = 0;
        sender_quiet  = 1'b0;
        sink_quiet    = 1'b0;
        filled        = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_item  <= '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue: every read end reports empty
        send_request(CMD_PEEK_FRONT, random_word());
        send_request(CMD_PEEK_BACK, random_word());
        send_request(CMD_POP_FRONT, random_word());
        send_request(CMD_POP_BACK, random_word());
        // extremes at both ends, front pushes wrap the head below zero
        send_request(CMD_PUSH_BACK, 32'h7fff_ffff);
        send_request(CMD_PUSH_FRONT, 32'h8000_0000);
        send_request(CMD_PUSH_BACK, '0);
        send_request(CMD_PUSH_FRONT, '1);
        send_request(CMD_PUSH_BACK, 32'h5555_5555);
        send_request(CMD_PUSH_FRONT, 32'haaaa_aaaa);
        send_request(CMD_PEEK_FRONT, random_word());
        send_request(CMD_PEEK_BACK, random_word());
        send_request(CMD_RESERVED, '1);
        send_request(CMD_POP_FRONT, random_word());
        send_request(CMD_POP_BACK, random_word());
        send_request(CMD_POP_FRONT, random_word());
        send_request(CMD_POP_BACK, random_word());
        send_request(CMD_POP_FRONT, random_word());
        send_request(CMD_POP_BACK, random_word());
        send_request(CMD_POP_BACK, random_word());
        // clear with entries held, then reads see empty again
        send_request(CMD_PUSH_BACK, random_word());
        send_request(CMD_PUSH_FRONT, random_word());
        send_request(CMD_CLEAR, random_word());
        send_request(CMD_PEEK_BACK, random_word());
        send_request(CMD_RESERVED, '0);

        // random segments, one of them filling the ring past capacity
        while (requests_sent < RANDOM_ITEMS) begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            sink_quiet   = ($urandom_range(0, 3) == 0);
            if (!filled && requests_sent >= 150) begin
                filled = 1'b1;
                send_request(CMD_CLEAR, random_word());
                repeat (CAPACITY + 6) begin
                    send_request($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                                 random_word());
                end
                send_request(CMD_PEEK_FRONT, random_word());
                send_request(CMD_PEEK_BACK, random_word());
                send_request(CMD_POP_BACK, random_word());
                send_request(CMD_PUSH_FRONT, random_word());
                send_request(CMD_PUSH_BACK, random_word());
                send_request(CMD_POP_FRONT, random_word());
            end else begin
                mix     = t_mix'($urandom_range(MIX_GROW, MIX_NOISE));
                seg_len = $urandom_range(16, 96);
                repeat (seg_len) send_request(pick_command(mix), random_word());
            end
        end
        req_valid <= 1'b0;

        // let the last results drain
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d requests sent, %0d results checked, %0d mismatches", requests_sent,
                 checked, mismatches);
        $display("empty reads refused %0d times, pushes refused at capacity %0d times",
                 empty_hits, full_hits);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
